>>> hw/rtl/point_rotate_two_axis_macros.svh
// Assertion macros used by the checker file.
`ifndef POINT_ROTATE_TWO_AXIS_MACROS_SVH
`define POINT_ROTATE_TWO_AXIS_MACROS_SVH

// Clocked property, switched off while reset is held.
`define PRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked in reset too.
`define PRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/prt_pkg.sv
// Types, widths and constants for the two-axis point rotator.
`timescale 1ns / 1ps
package prt_pkg;

    localparam int COORD_WIDTH        = 32;
    localparam int ANGLE_WIDTH        = 16;
    localparam int TRIG_FRACTION_BITS = 16;

    // CORDIC works on a 32-bit turn angle with 30 fraction bits in x and y.
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_FRAC  = 30;
    localparam int TURN_W       = 32;
    localparam int CW           = 34;
    localparam int TRIG_STAGES  = CORDIC_STEPS + 2;
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
    localparam logic signed [CW-1:0] TRIG_HALF   =
        CW'(64'sd1 <<< (CORDIC_FRAC - 1 - TRIG_FRACTION_BITS));

    // Trig values may reach one plus one lsb.
    localparam int TRIG_W  = TRIG_FRACTION_BITS + 2;
    // Width of a rotated coordinate after one rotation (exact, not saturated).
    localparam int MID_W   = COORD_WIDTH + TRIG_W + 1 - TRIG_FRACTION_BITS;
    localparam int PROD_W  = MID_W + TRIG_W;
    localparam int RSUM_W  = PROD_W + 1;
    localparam int ROT_W   = RSUM_W - TRIG_FRACTION_BITS;
    localparam logic signed [RSUM_W-1:0] ROT_HALF =
        RSUM_W'(64'sd1 <<< (TRIG_FRACTION_BITS - 1));

    // Output range limits at rotation width
    localparam logic signed [ROT_W-1:0] SAT_HI =
        ROT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ROT_W-1:0] SAT_LO =
        ROT_W'(-(64'sd1 <<< (COORD_WIDTH - 1)));

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } t_point;

    // Values carried beside a rotation unit.
    typedef struct packed {
        logic signed [MID_W-1:0]  x;
        logic signed [MID_W-1:0]  z1;
        logic signed [TRIG_W-1:0] cb;
        logic signed [TRIG_W-1:0] sb;
    } t_side;

    // atan(2^-i) as a fraction of a full turn times 2^32
    function automatic logic signed [CW-1:0] atan_turn(input int i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = CW'(536870912);
            1:  v = CW'(316933406);
            2:  v = CW'(167458907);
            3:  v = CW'(85004756);
            4:  v = CW'(42667331);
            5:  v = CW'(21354465);
            6:  v = CW'(10680862);
            7:  v = CW'(5340245);
            8:  v = CW'(2670163);
            9:  v = CW'(1335087);
            10: v = CW'(667544);
            11: v = CW'(333772);
            12: v = CW'(166886);
            13: v = CW'(83443);
            14: v = CW'(41721);
            15: v = CW'(20860);
            16: v = CW'(10430);
            17: v = CW'(5215);
            18: v = CW'(2607);
            19: v = CW'(1303);
            20: v = CW'(651);
            21: v = CW'(325);
            22: v = CW'(162);
            23: v = CW'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] saturate(
        input logic signed [ROT_W-1:0] v
    );
        logic signed [COORD_WIDTH-1:0] r;
        if (v > SAT_HI) begin
            r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else if (v < SAT_LO) begin
            r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            r = COORD_WIDTH'(v);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/prt_trig.sv
// Pipelined CORDIC: sine and cosine of two angles, point carried alongside.
`timescale 1ns / 1ps
module prt_trig import prt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    output logic                     o_rdy,
    input  logic [ANGLE_WIDTH-1:0]   i_angle_a,
    input  logic [ANGLE_WIDTH-1:0]   i_angle_b,
    input  t_point                   i_pt,
    output logic                     o_vld,
    input  logic                     i_rdy,
    output logic signed [TRIG_W-1:0] o_ca,
    output logic signed [TRIG_W-1:0] o_sa,
    output logic signed [TRIG_W-1:0] o_cb,
    output logic signed [TRIG_W-1:0] o_sb,
    output t_point                   o_pt
);

    localparam int NS = TRIG_STAGES;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS:0]   w_rdy;

    logic signed [CW-1:0] r_x [0:1][0:CORDIC_STEPS];
    logic signed [CW-1:0] r_y [0:1][0:CORDIC_STEPS];
    logic signed [CW-1:0] r_z [0:1][0:CORDIC_STEPS];
    logic                 r_flip [0:1][0:CORDIC_STEPS];
    t_point               r_pt [0:CORDIC_STEPS];

    logic signed [TRIG_W-1:0] r_c [0:1];
    logic signed [TRIG_W-1:0] r_s [0:1];
    t_point                   r_pt_o;

    logic [ANGLE_WIDTH-1:0] w_ang [0:1];

    assign w_ang[0] = i_angle_a;
    assign w_ang[1] = i_angle_b;

    // a stage loads when empty or when the next one moves on
    assign w_rdy[NS] = i_rdy;
    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_rdy
            assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    endgenerate

    assign n_vld = {r_vld[NS-2:0], i_vld};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (w_rdy[s]) begin
                    r_vld[s] <= n_vld[s];
                end
            end
        end
    end

    genvar l, i;
    generate
        for (l = 0; l < 2; l++) begin : g_lane
            logic [TURN_W-1:0] w_t;
            logic              w_flip;
            logic [TURN_W-1:0] w_t2;

            // quadrants two and three fold back by a half turn
            assign w_t    = TURN_W'(w_ang[l]) << (TURN_W - ANGLE_WIDTH);
            assign w_flip = w_t[TURN_W-1] ^ w_t[TURN_W-2];
            assign w_t2   = {w_t[TURN_W-1] ^ w_flip, w_t[TURN_W-2:0]};

            always_ff @(posedge i_clk) begin
                if (w_rdy[0]) begin
                    r_x[l][0]    <= CORDIC_GAIN;
                    r_y[l][0]    <= '0;
                    r_z[l][0]    <= CW'(signed'(w_t2));
                    r_flip[l][0] <= w_flip;
                end
            end

            for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
                logic                 w_dir;
                logic signed [CW-1:0] w_xs;
                logic signed [CW-1:0] w_ys;

                assign w_dir = !r_z[l][i][CW-1];
                assign w_xs  = r_x[l][i] >>> i;
                assign w_ys  = r_y[l][i] >>> i;

                always_ff @(posedge i_clk) begin
                    if (w_rdy[i+1]) begin
                        r_x[l][i+1]    <= w_dir ? r_x[l][i] - w_ys : r_x[l][i] + w_ys;
                        r_y[l][i+1]    <= w_dir ? r_y[l][i] + w_xs : r_y[l][i] - w_xs;
                        r_z[l][i+1]    <= w_dir ? r_z[l][i] - atan_turn(i)
                                                : r_z[l][i] + atan_turn(i);
                        r_flip[l][i+1] <= r_flip[l][i];
                    end
                end
            end

            logic signed [CW-1:0] w_xf;
            logic signed [CW-1:0] w_yf;
            logic signed [CW-1:0] w_cr;
            logic signed [CW-1:0] w_sr;

            assign w_xf = r_flip[l][CORDIC_STEPS] ? -r_x[l][CORDIC_STEPS]
                                                  : r_x[l][CORDIC_STEPS];
            assign w_yf = r_flip[l][CORDIC_STEPS] ? -r_y[l][CORDIC_STEPS]
                                                  : r_y[l][CORDIC_STEPS];
            assign w_cr = (w_xf + TRIG_HALF) >>> (CORDIC_FRAC - TRIG_FRACTION_BITS);
            assign w_sr = (w_yf + TRIG_HALF) >>> (CORDIC_FRAC - TRIG_FRACTION_BITS);

            always_ff @(posedge i_clk) begin
                if (w_rdy[NS-1]) begin
                    r_c[l] <= TRIG_W'(w_cr);
                    r_s[l] <= TRIG_W'(w_sr);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_pt[0] <= i_pt;
        end
        for (int s = 0; s < CORDIC_STEPS; s++) begin
            if (w_rdy[s+1]) begin
                r_pt[s+1] <= r_pt[s];
            end
        end
        if (w_rdy[NS-1]) begin
            r_pt_o <= r_pt[CORDIC_STEPS];
        end
    end

    assign o_rdy = w_rdy[0];
    assign o_vld = r_vld[NS-1];
    assign o_ca  = r_c[0];
    assign o_sa  = r_s[0];
    assign o_cb  = r_c[1];
    assign o_sb  = r_s[1];
    assign o_pt  = r_pt_o;

endmodule

>>> hw/rtl/prt_rot.sv
// One plane rotation: p = a*c - b*s, q = a*s + b*c, rounded, two stages.
`timescale 1ns / 1ps
module prt_rot import prt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    output logic                     o_rdy,
    input  logic signed [MID_W-1:0]  i_a,
    input  logic signed [MID_W-1:0]  i_b,
    input  logic signed [TRIG_W-1:0] i_c,
    input  logic signed [TRIG_W-1:0] i_s,
    input  t_side                    i_side,
    output logic                     o_vld,
    input  logic                     i_rdy,
    output logic signed [ROT_W-1:0]  o_p,
    output logic signed [ROT_W-1:0]  o_q,
    output t_side                    o_side
);

    logic [1:0] r_vld;
    logic [2:0] w_rdy;

    logic signed [PROD_W-1:0] r_ac;
    logic signed [PROD_W-1:0] r_bs;
    logic signed [PROD_W-1:0] r_as;
    logic signed [PROD_W-1:0] r_bc;
    t_side                    r_side1;

    logic signed [ROT_W-1:0] r_p;
    logic signed [ROT_W-1:0] r_q;
    t_side                   r_side2;

    logic signed [RSUM_W-1:0] w_psum;
    logic signed [RSUM_W-1:0] w_qsum;

    assign w_rdy[2] = i_rdy;
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_ac    <= i_a * i_c;
            r_bs    <= i_b * i_s;
            r_as    <= i_a * i_s;
            r_bc    <= i_b * i_c;
            r_side1 <= i_side;
        end
    end

    assign w_psum = RSUM_W'(r_ac) - RSUM_W'(r_bs) + ROT_HALF;
    assign w_qsum = RSUM_W'(r_as) + RSUM_W'(r_bc) + ROT_HALF;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_p     <= ROT_W'(w_psum >>> TRIG_FRACTION_BITS);
            r_q     <= ROT_W'(w_qsum >>> TRIG_FRACTION_BITS);
            r_side2 <= r_side1;
        end
    end

    assign o_rdy  = w_rdy[0];
    assign o_vld  = r_vld[1];
    assign o_p    = r_p;
    assign o_q    = r_q;
    assign o_side = r_side2;

endmodule

>>> hw/rtl/point_rotate_two_axis.sv
// Two-axis point rotator: top level.
//
// Rotates a Q16.16 point about x by angle A, then about z by angle B.
// Input channel: i_valid with i_in_x/y/z and i_angle_a/b; the request is
// taken on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid with o_out_x/y/z; the receiver holds i_stall high
// to keep the request in place.
// Throughput: one point per cycle unless the output is stalled, no state between points.
// Pipeline from accept to o_valid: the CORDIC stages (angle fold, 24 micro-rotations,
// round), the multiply stage and the add-and-round stage of each rotation unit,
// and saturation into the output register.
// Each stage loads when it is empty or its successor moves, so bubbles are
// squeezed out and the input keeps being taken while a result waits; o_stall
// rises only once every stage holds a point and i_stall is high.
// Reset (i_rst_n low, synchronous) drops all valid bits; data registers are
// not cleared.
`timescale 1ns / 1ps
module point_rotate_two_axis import prt_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_in_x,
    input  logic signed [COORD_WIDTH-1:0] i_in_y,
    input  logic signed [COORD_WIDTH-1:0] i_in_z,
    input  logic [ANGLE_WIDTH-1:0]        i_angle_a,
    input  logic [ANGLE_WIDTH-1:0]        i_angle_b,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z
);

    t_point w_pt_in;
    t_point w_pt_t;
    logic   w_trig_rdy;
    logic   w_trig_vld;
    logic   w_r1_rdy;
    logic   w_r1_vld;
    logic   w_r2_rdy;
    logic   w_r2_vld;
    logic   w_out_rdy;

    logic signed [TRIG_W-1:0] w_ca;
    logic signed [TRIG_W-1:0] w_sa;
    logic signed [TRIG_W-1:0] w_cb;
    logic signed [TRIG_W-1:0] w_sb;

    t_side                   w_side1_in;
    t_side                   w_side1_out;
    t_side                   w_side2_in;
    t_side                   w_side2_out;
    logic signed [ROT_W-1:0] w_y1;
    logic signed [ROT_W-1:0] w_z1;
    logic signed [ROT_W-1:0] w_xo;
    logic signed [ROT_W-1:0] w_yo;

    logic                          r_ovld;
    logic signed [COORD_WIDTH-1:0] r_x;
    logic signed [COORD_WIDTH-1:0] r_y;
    logic signed [COORD_WIDTH-1:0] r_z;

    assign w_pt_in = '{x: i_in_x, y: i_in_y, z: i_in_z};

    prt_trig u_trig (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (i_valid),
        .o_rdy     (w_trig_rdy),
        .i_angle_a (i_angle_a),
        .i_angle_b (i_angle_b),
        .i_pt      (w_pt_in),
        .o_vld     (w_trig_vld),
        .i_rdy     (w_r1_rdy),
        .o_ca      (w_ca),
        .o_sa      (w_sa),
        .o_cb      (w_cb),
        .o_sb      (w_sb),
        .o_pt      (w_pt_t)
    );

    assign w_side1_in = '{x: MID_W'(w_pt_t.x), z1: '0, cb: w_cb, sb: w_sb};

    // about x: y1 = y*cA - z*sA, z1 = y*sA + z*cA
    prt_rot u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_trig_vld),
        .o_rdy   (w_r1_rdy),
        .i_a     (MID_W'(w_pt_t.y)),
        .i_b     (MID_W'(w_pt_t.z)),
        .i_c     (w_ca),
        .i_s     (w_sa),
        .i_side  (w_side1_in),
        .o_vld   (w_r1_vld),
        .i_rdy   (w_r2_rdy),
        .o_p     (w_y1),
        .o_q     (w_z1),
        .o_side  (w_side1_out)
    );

    // y1 and z1 always fit MID_W; the upper bits are sign copies
    assign w_side2_in = '{x: '0, z1: MID_W'(w_z1), cb: '0, sb: '0};

    prt_rot u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_r1_vld),
        .o_rdy   (w_r2_rdy),
        .i_a     (w_side1_out.x),
        .i_b     (MID_W'(w_y1)),
        .i_c     (w_side1_out.cb),
        .i_s     (w_side1_out.sb),
        .i_side  (w_side2_in),
        .o_vld   (w_r2_vld),
        .i_rdy   (w_out_rdy),
        .o_p     (w_xo),
        .o_q     (w_yo),
        .o_side  (w_side2_out)
    );

    assign w_out_rdy = !r_ovld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_rdy) begin
            r_ovld <= w_r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy) begin
            r_x <= saturate(w_xo);
            r_y <= saturate(w_yo);
            r_z <= saturate(ROT_W'(w_side2_out.z1));
        end
    end

    assign o_stall = !w_trig_rdy;
    assign o_valid = r_ovld;
    assign o_out_x = r_x;
    assign o_out_y = r_y;
    assign o_out_z = r_z;

endmodule

>>> hw/rtl/prt_checker.sv
// Port-level checks for the two-axis point rotator, bound to the top level.
`timescale 1ns / 1ps
`include "point_rotate_two_axis_macros.svh"
module prt_checker import prt_pkg::*; (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [COORD_WIDTH-1:0] o_out_x,
    input logic signed [COORD_WIDTH-1:0] o_out_y,
    input logic signed [COORD_WIDTH-1:0] o_out_z
);

    // nothing comes out in the cycle after reset
    `PRT_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> !o_valid, "valid after reset")

    // input backs up only when the output is full and held
    `PRT_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall), "stall with free output")

    // a held result keeps its value
    `PRT_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z)), "held result changed")

    // stall toward the sender ends once the receiver's stall is released
    `PRT_ASSERT(a_stall_release, i_clk, i_rst_n, (o_stall && !i_stall) |=> !o_stall, "stall not released")

endmodule

bind point_rotate_two_axis prt_checker u_prt_checker (.*);

>>> verif/tb_point_rotate_two_axis.sv
// Testbench for the two-axis point rotator: directed table, then random points.
`timescale 1ns / 1ps
module tb_point_rotate_two_axis;
    import prt_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [ANGLE_WIDTH-1:0] t_angle;

    typedef struct {
        t_coord x, y, z;
        t_angle a, b;
        bit     typed;
        t_coord ex, ey, ez;
    } t_row;

    localparam t_coord CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_angle QTURN = t_angle'(1 << (ANGLE_WIDTH - 2));
    localparam t_angle HTURN = t_angle'(1 << (ANGLE_WIDTH - 1));
    localparam int TIMEOUT_CYCLES = 400000;

    logic   i_clk, i_rst_n, i_valid, i_stall;
    logic   o_stall, o_valid;
    t_coord i_in_x, i_in_y, i_in_z, o_out_x, o_out_y, o_out_z;
    t_angle i_angle_a, i_angle_b;

    int     send_idle_pct, recv_idle_pct;
    int     fail_count;
    t_point expected_points[$];

    point_rotate_two_axis u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(4 * TIMEOUT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // CORDIC sine/cosine of a turn fraction, rounded to the trig format
    function automatic void sin_cos(input t_angle ang, output longint c, output longint s);
        logic [31:0] t;
        bit     flip;
        longint cx, cy, cz, nx;
        longint atan_tab[24] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10680862, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41721, 20860, 10430, 5215, 2607, 1303, 651,
            325, 162, 81};
        t = {ang, {(32-ANGLE_WIDTH){1'b0}}};
        flip = t[31] ^ t[30];
        if (flip) t = t + 32'h8000_0000;
        cz = longint'($signed(t));
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < 24; i++) begin
            if (cz >= 0) begin
                nx = cx - floor_shr(cy, i);
                cy = cy + floor_shr(cx, i);
                cz -= atan_tab[i];
            end else begin
                nx = cx + floor_shr(cy, i);
                cy = cy - floor_shr(cx, i);
                cz += atan_tab[i];
            end
            cx = nx;
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        c = floor_shr(cx + (64'sd1 << (29 - TRIG_FRACTION_BITS)), 30 - TRIG_FRACTION_BITS);
        s = floor_shr(cy + (64'sd1 << (29 - TRIG_FRACTION_BITS)), 30 - TRIG_FRACTION_BITS);
    endfunction

    // round((a*ta + b*tb) / 2^frac), exact at 128 bits
    function automatic longint rot_sum(longint a, longint ta, longint b, longint tb);
        logic signed [127:0] acc;
        acc = 128'(a) * 128'(ta) + 128'(b) * 128'(tb)
            + (128'sd1 <<< (TRIG_FRACTION_BITS - 1));
        return longint'(acc >>> TRIG_FRACTION_BITS);
    endfunction

    function automatic t_coord clamp(longint v);
        if (v > longint'(CMAX)) return CMAX;
        if (v < longint'(CMIN)) return CMIN;
        return t_coord'(v);
    endfunction

    function automatic t_point rotate_point(t_coord x, t_coord y, t_coord z,
                                            t_angle a, t_angle b);
        longint ca, sa, cb, sb, y1, z1;
        t_point p;
        sin_cos(a, ca, sa);
        sin_cos(b, cb, sb);
        y1 = rot_sum(y, ca, z, -sa);
        z1 = rot_sum(y, sa, z, ca);
        p.x = clamp(rot_sum(x, cb, y1, -sb));
        p.y = clamp(rot_sum(x, sb, y1, cb));
        p.z = clamp(z1);
        return p;
    endfunction

    task automatic report_mismatch(input string what, input t_coord got, input t_coord want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Sender: hold the request until accepted, idle at random between.
    task automatic send_point(input t_row r);
        t_point p;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        if (r.typed) begin
            p.x = r.ex;
            p.y = r.ey;
            p.z = r.ez;
        end else begin
            p = rotate_point(r.x, r.y, r.z, r.a, r.b);
        end
        i_valid   <= 1'b1;
        i_in_x    <= r.x;
        i_in_y    <= r.y;
        i_in_z    <= r.z;
        i_angle_a <= r.a;
        i_angle_b <= r.b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_points.push_back(p);
    endtask

    // Receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
            if (o_valid && !i_stall) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected point", o_out_x, 'x);
                end else begin
                    t_point e;
                    e = expected_points.pop_front();
                    if (o_out_x !== e.x) report_mismatch("x", o_out_x, e.x);
                    if (o_out_y !== e.y) report_mismatch("y", o_out_y, e.y);
                    if (o_out_z !== e.z) report_mismatch("z", o_out_z, e.z);
                end
            end
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(5))
            0: return t_coord'($urandom_range(7)) - 4;
            1: return $urandom_range(1) ? CMAX - $urandom_range(3) : CMIN + $urandom_range(3);
            2: return t_coord'($signed($urandom_range(32'h3_FFFF))) - 32'sh2_0000;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_angle rand_angle();
        case ($urandom_range(3))
            0: return t_angle'($urandom_range(3)) * QTURN + t_angle'($urandom_range(2)) - 1;
            default: return t_angle'($urandom);
        endcase
    endfunction

    t_row dir_rows[] = '{
        // zero angles leave the point alone
        '{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 1,
          32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000},
        '{0, 0, 0, 16'h1234, 16'hBEEF, 1, 0, 0, 0},
        '{CMAX, CMAX, CMAX, 0, 0, 1, CMAX, CMAX, CMAX},
        '{CMIN, CMIN, CMIN, 0, 0, 1, CMIN, CMIN, CMIN},
        '{CMAX, CMIN, CMAX, QTURN, 0, 0, 0, 0, 0},
        '{CMIN, CMAX, CMIN, HTURN, HTURN, 0, 0, 0, 0},
        '{CMAX, CMAX, CMAX, 16'h2000, 16'h2000, 0, 0, 0, 0},
        '{CMIN, CMIN, CMIN, 16'h6000, 16'hA000, 0, 0, 0, 0},
        '{32'sh0001_0000, 0, 0, 0, QTURN, 0, 0, 0, 0},
        '{0, 32'sh0001_0000, 0, QTURN, 0, 0, 0, 0, 0},
        '{0, 0, 32'sh0001_0000, 3 * QTURN, HTURN, 0, 0, 0, 0},
        // just either side of the fold boundaries
        '{32'sh0005_8000, -32'sh0003_0000, 32'sh0001_1111, QTURN - 1, QTURN + 1, 0, 0, 0, 0},
        '{-32'sh0005_8000, 32'sh0003_0000, -32'sh0001_1111, 3 * QTURN - 1, 3 * QTURN, 0, 0, 0, 0},
        '{32'sh1234_5678, 32'shEDCB_A987, 32'h7FFF_0001, 16'hFFFF, 16'h0001, 0, 0, 0, 0},
        '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 16'hAAAA, 16'h5555, 0, 0, 0, 0},
        '{-1, -1, -1, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0},
        '{1, 1, 1, HTURN - 1, HTURN + 1, 0, 0, 0, 0}
    };

    initial begin
        t_row r;
        int   waited;
        fail_count    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in_x    = '0;
        i_in_y    = '0;
        i_in_z    = '0;
        i_angle_a = '0;
        i_angle_b = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) send_point(dir_rows[k]);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 82 : 0;
            recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 36 : 0;
            for (int n = 0; n < 210; n++) begin
                r.x = rand_coord();
                r.y = rand_coord();
                r.z = rand_coord();
                r.a = rand_angle();
                r.b = rand_angle();
                r.typed = 0;
                send_point(r);
                // occasional burst with no gaps from either side
                if (n % 60 == 59) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    repeat ($urandom_range(10, 20)) begin
                        r.x = t_coord'($urandom);
                        r.y = t_coord'($urandom);
                        r.z = t_coord'($urandom);
                        r.a = t_angle'($urandom);
                        r.b = t_angle'($urandom);
                        send_point(r);
                    end
                    send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 82 : 0;
                    recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 36 : 0;
                end
            end
        end
        i_valid <= 1'b0;
        recv_idle_pct = 0;

        waited = 0;
        while (expected_points.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && expected_points.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
